/* rtl/hcbp_pkg.sv */
package hcbp_pkg;

  localparam int BYTE_W       = 8;
  localparam int BYTE_SH      = 3;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMS         = 256;
  localparam int ADDR_W       = 8;
  localparam int FILL_W       = 4;
  localparam int CNT_W        = 64;
  localparam int CNT_BYTES    = CNT_W / BYTE_W;
  localparam int STREAM_W     = BYTE_W + MAX_CODE_LEN;
  localparam int TOT_W        = $clog2(STREAM_W + 1);
  localparam int SYM_BYTES    = (STREAM_W - 1) / BYTE_W;
  localparam int EMIT_W       = $clog2(SYM_BYTES + 1);
  localparam int BURST_N      = 2 + CNT_BYTES;
  localparam int BCNT_W       = $clog2(BURST_N + 1);

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SYMBOL = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // group of result bytes handed from the packer to the output register
  typedef struct packed {
    logic                            load;
    logic [BCNT_W-1:0]               cnt;
    logic [BURST_N-1:0][BYTE_W-1:0]  data;
    logic [BURST_N-1:0]              last;
  } burst_t;

endpackage

/* rtl/hcbp_table.sv */
module hcbp_table
  import hcbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [CODE_W-1:0] wr_bits,
  input  logic [LEN_W-1:0]  wr_len,
  output entry_t            rd_entry
);

  entry_t           mem [SYMS];
  logic [SYMS-1:0]  valid_r;
  logic [SYMS-1:0]  valid_nxt;
  entry_t           rd_r;
  logic             rd_valid_r;
  entry_t           wr_entry;

  always_comb begin
    wr_entry.bits = wr_bits;
    wr_entry.len  = (wr_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : wr_len;
    valid_nxt     = valid_r;
    if (wr_en) begin
      valid_nxt[addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_r       <= mem[addr];
      rd_valid_r <= valid_r[addr];
    end
  end

  always_comb begin
    rd_entry.bits = rd_r.bits;
    rd_entry.len  = rd_valid_r ? rd_r.len : '0;
  end

endmodule

/* rtl/hcbp_pack.sv */
module hcbp_pack
  import hcbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic [1:0] in_kind,
  input  entry_t     entry,
  input  logic       burst_ready,
  output logic       stage_free,
  output burst_t     burst
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [1:0]        s1_kind_r;
  logic [BYTE_W-1:0] buf_r, buf_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  bw_r, bw_nxt;

  logic [STREAM_W-1:0] code_v;
  logic [STREAM_W-1:0] v;
  logic [STREAM_W-1:0] align;
  logic [TOT_W-1:0]    total;
  logic [EMIT_W-1:0]   emit;
  logic [FILL_W-1:0]   new_fill;
  logic [BYTE_W-1:0]   last_b;
  logic [CNT_W-1:0]    cnt1;
  logic                is_sym, is_end, advance;

  always_comb begin
    is_sym   = (s1_kind_r == KIND_SYMBOL) && (entry.len != '0);
    is_end   = (s1_kind_r == KIND_END);

    code_v   = STREAM_W'(entry.bits) & ((STREAM_W'(1) << entry.len) - STREAM_W'(1));
    v        = (STREAM_W'(buf_r) << entry.len) | code_v;
    total    = TOT_W'(fill_r) + TOT_W'(entry.len);
    emit     = EMIT_W'((total - TOT_W'(1)) >> BYTE_SH);
    new_fill = FILL_W'(total - (TOT_W'(emit) << BYTE_SH));
    align    = v << (TOT_W'(STREAM_W) - total);

    last_b   = fill_r[FILL_W-1] ? buf_r : BYTE_W'(buf_r << (FILL_W'(BYTE_W) - fill_r));
    cnt1     = bw_r + CNT_W'(1);

    burst.data = '0;
    burst.last = '0;
    burst.cnt  = '0;
    if (is_sym) begin
      burst.cnt = BCNT_W'(emit);
      for (int k = 0; k < SYM_BYTES; k++) begin
        burst.data[k] = align[STREAM_W-1-BYTE_W*k -: BYTE_W];
      end
    end else if (is_end) begin
      burst.cnt     = BCNT_W'(BURST_N);
      burst.data[0] = last_b;
      burst.data[1] = BYTE_W'(fill_r);
      for (int j = 0; j < CNT_BYTES; j++) begin
        burst.data[2+j] = cnt1[CNT_W-1-BYTE_W*j -: BYTE_W];
      end
      burst.last[BURST_N-1] = 1'b1;
    end

    advance    = s1_valid_r && ((burst.cnt == '0) || burst_ready);
    burst.load = advance && (burst.cnt != '0);
    stage_free = !s1_valid_r || advance;

    s1_valid_nxt = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    bw_nxt   = bw_r;
    if (advance && is_sym) begin
      buf_nxt  = BYTE_W'(v & ((STREAM_W'(1) << new_fill) - STREAM_W'(1)));
      fill_nxt = new_fill;
      bw_nxt   = bw_r + CNT_W'(emit);
    end else if (advance && is_end) begin
      buf_nxt  = '0;
      fill_nxt = '0;
      bw_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      buf_r      <= '0;
      fill_r     <= '0;
      bw_r       <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      buf_r      <= buf_nxt;
      fill_r     <= fill_nxt;
      bw_r       <= bw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r <= in_kind;
    end
  end

endmodule

/* rtl/hcbp_out.sv */
module hcbp_out
  import hcbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  burst_t            burst,
  output logic              burst_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  logic [BCNT_W-1:0]              cnt_r, cnt_nxt;
  logic [BURST_N-1:0][BYTE_W-1:0] data_r, data_nxt;
  logic [BURST_N-1:0]             last_r, last_nxt;

  always_comb begin
    out_valid   = (cnt_r != '0);
    out_byte    = data_r[0];
    out_last    = last_r[0];
    burst_ready = (cnt_r == '0) || ((cnt_r == BCNT_W'(1)) && out_ready);

    cnt_nxt  = cnt_r;
    data_nxt = data_r;
    last_nxt = last_r;
    if (burst.load) begin
      cnt_nxt  = burst.cnt;
      data_nxt = burst.data;
      last_nxt = burst.last;
    end else if (out_valid && out_ready) begin
      cnt_nxt = cnt_r - BCNT_W'(1);
      for (int i = 0; i < BURST_N - 1; i++) begin
        data_nxt[i] = data_r[i+1];
        last_nxt[i] = last_r[i+1];
      end
      data_nxt[BURST_N-1] = '0;
      last_nxt[BURST_N-1] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

endmodule

/* rtl/huffman_code_bit_packer.sv */
// channel  ports                                                  dir
// in       in_valid in_ready in_kind in_symbol in_code_bits        sink
//          in_code_length
// out      out_valid out_ready out_byte out_last_of_stream         source
//
// One item per cycle unless stalled: table read on accept, packing in the next cycle.
// A symbol gives 0..4 beats, an end item 10; the output register sends
// one beat per cycle while out_ready is high, so bursts stall the input.
// Reset clears control, stream state and table entry valid bits.
module huffman_code_bit_packer
  import hcbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [ADDR_W-1:0] in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_stream
);

  logic   accept;
  entry_t entry;
  burst_t burst;
  logic   burst_ready;

  assign accept = in_valid && in_ready;

  hcbp_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .wr_en    (accept && (in_kind == KIND_LOAD)),
    .addr     (in_symbol),
    .wr_bits  (in_code_bits),
    .wr_len   (in_code_length),
    .rd_entry (entry)
  );

  hcbp_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (accept),
    .in_kind     (in_kind),
    .entry       (entry),
    .burst_ready (burst_ready),
    .stage_free  (in_ready),
    .burst       (burst)
  );

  hcbp_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .burst       (burst),
    .burst_ready (burst_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last_of_stream)
  );

endmodule

/* tb/packer_checker.sv */
module packer_checker
  import hcbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [ADDR_W-1:0] in_symbol,
  input  logic [CODE_W-1:0] in_code_bits,
  input  logic [LEN_W-1:0]  in_code_length,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              out_last_of_stream,
  output int                mismatches,
  output int                outstanding,
  output int                beats_seen
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_beat_t;

  out_beat_t         expected_bytes[$];
  logic [CODE_W-1:0] tbl_bits [SYMS];
  logic [LEN_W-1:0]  tbl_len [SYMS];
  logic [BYTE_W-1:0] shift_reg;
  logic [FILL_W-1:0] fill;
  logic [CNT_W-1:0]  data_byte_total;
  int                err_cnt = 0;
  int                seen_cnt = 0;

  function automatic void queue_byte(input logic [BYTE_W-1:0] data, input logic last);
    out_beat_t b;
    b.data = data;
    b.last = last;
    expected_bytes.push_back(b);
  endfunction

  function automatic void store_code(input logic [ADDR_W-1:0] sym,
                                     input logic [CODE_W-1:0] bits,
                                     input logic [LEN_W-1:0] len);
    tbl_bits[sym] = bits;
    tbl_len[sym]  = (len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len;
  endfunction

  // shift code MSB first; a full byte leaves only when the next bit comes in
  function automatic void pack_symbol(input logic [ADDR_W-1:0] sym);
    logic [CODE_W-1:0] code;
    int                i;
    code = tbl_bits[sym];
    for (i = int'(tbl_len[sym]) - 1; i >= 0; i--) begin
      if (fill == FILL_W'(BYTE_W)) begin
        queue_byte(shift_reg, 1'b0);
        shift_reg = '0;
        fill = '0;
        data_byte_total++;
      end
      shift_reg = {shift_reg[BYTE_W-2:0], code[i]};
      fill++;
    end
  endfunction

  // trailer: last data byte left-aligned, fill count, 8-byte big-endian count
  function automatic void close_stream();
    logic [BYTE_W-1:0] tail;
    int                s;
    data_byte_total++;
    tail = (fill < FILL_W'(BYTE_W)) ? shift_reg << (BYTE_W - fill) : shift_reg;
    queue_byte(tail, 1'b0);
    queue_byte(BYTE_W'(fill), 1'b0);
    for (s = CNT_BYTES - 1; s >= 0; s--)
      queue_byte(data_byte_total[BYTE_W*s +: BYTE_W], s == 0);
    shift_reg = '0;
    fill = '0;
    data_byte_total = '0;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      for (int k = 0; k < SYMS; k++) begin
        tbl_bits[k] = '0;
        tbl_len[k]  = '0;
      end
      shift_reg = '0;
      fill = '0;
      data_byte_total = '0;
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen_cnt++;
        if (expected_bytes.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
                   $time, out_byte, out_last_of_stream);
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_byte) begin
            err_cnt++;
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.data, out_byte);
          end
          if (want.last !== out_last_of_stream) begin
            err_cnt++;
            $display("%0t: out_last_of_stream mismatch, expected %0b, actual %0b",
                     $time, want.last, out_last_of_stream);
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_kind)
          KIND_LOAD:   store_code(in_symbol, in_code_bits, in_code_length);
          KIND_SYMBOL: pack_symbol(in_symbol);
          KIND_END:    close_stream();
          default:     ;
        endcase
      end
    end
    mismatches  <= err_cnt;
    outstanding <= expected_bytes.size();
    beats_seen  <= seen_cnt;
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import hcbp_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         HOLD_CYCLES = 80;
  localparam int         RANDOM_ITEMS = 90;
  localparam int         QUIET_ITEMS = 30;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_kind;
  logic [ADDR_W-1:0] in_symbol;
  logic [CODE_W-1:0] in_code_bits;
  logic [LEN_W-1:0]  in_code_length;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last_of_stream;

  int                mismatches;
  int                outstanding;
  int                beats_seen;

  logic              quiet = 1'b0;
  logic              hold_req = 1'b0;
  logic [ADDR_W-1:0] known_syms[$];
  int                n_load = 0;
  int                n_sym = 0;
  int                n_end = 0;
  int                n_unused = 0;

  huffman_code_bit_packer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_symbol          (in_symbol),
    .in_code_bits       (in_code_bits),
    .in_code_length     (in_code_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_last_of_stream (out_last_of_stream)
  );

  packer_checker u_packer_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_symbol          (in_symbol),
    .in_code_bits       (in_code_bits),
    .in_code_length     (in_code_length),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_last_of_stream (out_last_of_stream),
    .mismatches         (mismatches),
    .outstanding        (outstanding),
    .beats_seen         (beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("timeout: %0d beats still expected", outstanding);
    $display("FAIL");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 19)) @(posedge clk);
      end
    end
  end

  task automatic put_item(input logic [1:0] kind, input logic [ADDR_W-1:0] sym,
                          input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_symbol      <= sym;
    in_code_bits   <= bits;
    in_code_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (kind)
      KIND_LOAD:   n_load++;
      KIND_SYMBOL: n_sym++;
      KIND_END:    n_end++;
      default:     n_unused++;
    endcase
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [ADDR_W-1:0] pick_symbol();
    if (known_syms.size() != 0 && $urandom_range(0, 99) < 85)
      return known_syms[$urandom_range(0, known_syms.size() - 1)];
    return ADDR_W'($urandom_range(0, SYMS - 1));
  endfunction

  // mostly short codes, some long, a few overlong or empty
  task automatic load_random_code(input logic [ADDR_W-1:0] sym);
    int          pick;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      len = '0;
    else if (pick < 14)
      len = LEN_W'($urandom_range(1, 10));
    else if (pick < 18)
      len = LEN_W'($urandom_range(11, MAX_CODE_LEN));
    else
      len = LEN_W'($urandom_range(MAX_CODE_LEN + 1, (1 << LEN_W) - 1));
    put_item(KIND_LOAD, sym, $urandom, len);
    known_syms.push_back(sym);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)
      load_random_code(ADDR_W'($urandom_range(0, SYMS - 1)));
    else if (r < 9)
      put_item(KIND_UNUSED, ADDR_W'($urandom), $urandom, LEN_W'($urandom));
    else if (r < 19)
      put_item(KIND_END, ADDR_W'($urandom), $urandom, LEN_W'($urandom));
    else
      put_item(KIND_SYMBOL, pick_symbol(), $urandom, LEN_W'($urandom));
    maybe_gap();
  endtask

  initial begin
    int target;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_LOAD;
    in_symbol      = '0;
    in_code_bits   = '0;
    in_code_length = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    put_item(KIND_END, 8'h00, 32'h0, 6'd0);             // empty stream
    put_item(KIND_SYMBOL, 8'h07, 32'hFFFFFFFF, 6'd63);  // no code
    maybe_gap();
    put_item(KIND_LOAD, 8'h01, 32'h000000A5, 6'd8);
    put_item(KIND_SYMBOL, 8'h01, 32'h0, 6'd0);          // buffer exactly full
    put_item(KIND_END, 8'hFF, 32'h0, 6'd0);
    put_item(KIND_LOAD, 8'h00, 32'hFFFFFFFF, 6'd32);
    maybe_gap();
    put_item(KIND_LOAD, 8'hFF, 32'h00000000, 6'd1);
    put_item(KIND_LOAD, 8'hAA, 32'hDEADBEEF, 6'd63);    // overlong
    put_item(KIND_LOAD, 8'h55, 32'h80000001, 6'd33);
    put_item(KIND_LOAD, 8'h02, 32'hFFFFFFFF, 6'd0);     // loaded with no code
    put_item(KIND_UNUSED, 8'h01, 32'h12345678, 6'd5);
    maybe_gap();
    put_item(KIND_SYMBOL, 8'h00, 32'h0, 6'd0);
    put_item(KIND_SYMBOL, 8'hFF, 32'h0, 6'd0);
    put_item(KIND_SYMBOL, 8'hAA, 32'h0, 6'd0);
    put_item(KIND_SYMBOL, 8'h55, 32'h0, 6'd0);
    put_item(KIND_SYMBOL, 8'h02, 32'h0, 6'd0);
    maybe_gap();
    put_item(KIND_SYMBOL, 8'h01, 32'h0, 6'd0);
    put_item(KIND_END, 8'h00, 32'h0, 6'd0);
    known_syms = '{8'h00, 8'h01, 8'hFF, 8'hAA, 8'h55};

    wait_drained();

    repeat (16) load_random_code(ADDR_W'($urandom_range(0, SYMS - 1)));

    // long receiver hold-off with back-to-back input
    hold_req <= 1'b1;
    repeat (24) put_item(KIND_SYMBOL, pick_symbol(), $urandom, LEN_W'($urandom));
    put_item(KIND_END, ADDR_W'($urandom), $urandom, LEN_W'($urandom));

    target = n_load + n_sym + n_end + RANDOM_ITEMS;
    while (n_load + n_sym + n_end < target) random_item();

    wait_drained();
    quiet <= 1'b1;
    target = n_load + n_sym + n_end + QUIET_ITEMS;
    while (n_load + n_sym + n_end < target) random_item();
    put_item(KIND_END, ADDR_W'($urandom), $urandom, LEN_W'($urandom));

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d loads, %0d symbols, %0d stream ends, %0d ignored items",
             n_load, n_sym, n_end, n_unused);
    $display("Checked %0d output beats incl. empty/full-buffer ends and a long stall",
             beats_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
